/* rtl/core/min_rtt_path_failover_selector_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the path selector
// Shared property forms. Each one is clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MIN_RTT_PATH_FAILOVER_SELECTOR_DEFINES_SVH
`define MIN_RTT_PATH_FAILOVER_SELECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mrps_pkg.sv */
// ----------------------------------------------------------------------------
// mrps_pkg
// Types, field widths and codes shared by the path selector files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrps_pkg;

  localparam int PATHS_DEFAULT = 8;

  localparam int MODE_W   = 3;
  localparam int IDX_W    = 3;
  localparam int RTT_W    = 16;
  localparam int BYTES_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SELECT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FAILOVER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ACCOUNT  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ACTIVE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  // A new path starts with this round-trip time, in milliseconds.
  localparam logic [RTT_W-1:0] RTT_START = 16'd1000;

  // Status returned by the minimum-RTT scan unit.
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

/* rtl/core/mrps_req_if.sv */
// ----------------------------------------------------------------------------
// mrps_req_if
// Request channel: valid/ready handshake and the request fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mrps_req_if import mrps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [IDX_W-1:0]     path_index;
  logic                 link_up;
  logic [RTT_W-1:0]     rtt_value;
  logic [BYTES_W-1:0]   byte_count;

  modport source (output valid, mode, path_index, link_up, rtt_value, byte_count,
                  input ready);
  modport sink (input valid, mode, path_index, link_up, rtt_value, byte_count,
                output ready);
endinterface

/* rtl/core/mrps_rsp_if.sv */
// ----------------------------------------------------------------------------
// mrps_rsp_if
// Response channel: valid/ready handshake and the response fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mrps_rsp_if import mrps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 index_valid;
  logic [IDX_W-1:0]     returned_index;
  logic                 active_valid;
  logic [IDX_W-1:0]     active_path;
  logic [COUNT_W-1:0]   up_count;
  logic [BYTES_W-1:0]   path_bytes;

  modport source (output valid, status, index_valid, returned_index, active_valid,
                  active_path, up_count, path_bytes,
                  input ready);
  modport sink (input valid, status, index_valid, returned_index, active_valid,
                active_path, up_count, path_bytes,
                output ready);
endinterface

/* rtl/core/min_rtt_path_failover_selector.sv */
// ----------------------------------------------------------------------------
// min_rtt_path_failover_selector
// Add, update, account and query go from apply through byte read and byte data
// to finish; a refused request or one that addresses no path goes from apply
// straight to finish. Select and failover scan the paths in use first.
// Requests are taken one at a time; ready returns the cycle after the response
// register loads, which can wait while the response is stalled.
// Reset clears the path table, the active path and the byte counters at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_rtt_path_failover_selector import mrps_pkg::*; #(
  parameter int PATHS = PATHS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  mrps_req_if.sink   req,
  mrps_rsp_if.source rsp
);

  localparam int IW = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int CW = $clog2(PATHS + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPLY  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_BREAD  = 3'd3;
  localparam logic [2:0] S_BDATA  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]          state;
  logic [MODE_W-1:0]   mode_q;
  logic [IDX_W-1:0]    idx_q;
  logic                up_q;
  logic [RTT_W-1:0]    rtt_q;
  logic [BYTES_W-1:0]  bytes_q;
  logic [IW-1:0]       target;
  logic [CW-1:0]       paths_in_use;
  logic                has_active;
  logic [IW-1:0]       active_slot;
  logic [PATHS-1:0]    up_flags;
  logic [CW-1:0]       up_total;
  logic [STATUS_W-1:0] status_q;
  logic                ret_valid_q;
  logic [IW-1:0]       ret_q;
  logic [BYTES_W-1:0]  pbytes_q;
  logic                out_valid;

  logic                accept;
  logic                idx_ok;
  logic                full;
  logic [IW-1:0]       idx_slot;
  logic [IW-1:0]       new_slot;
  logic                rtt_wr_en;
  logic [IW-1:0]       rtt_wr_addr;
  logic [RTT_W-1:0]    rtt_wr_data;
  logic                scan_start;
  scan_stat_t          scan_stat;
  logic [IW-1:0]       scan_best;
  logic [BYTES_W-1:0]  byte_rd;
  logic [BYTES_W-1:0]  byte_sum;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;

  assign idx_ok   = XW'(idx_q) < XW'(paths_in_use);
  assign full     = (paths_in_use == CW'(PATHS));
  assign idx_slot = IW'(idx_q);
  assign new_slot = IW'(paths_in_use);
  assign byte_sum = byte_rd + bytes_q;

  assign scan_start = (state == S_APPLY) &&
                      ((mode_q == MODE_SELECT) || ((mode_q == MODE_FAILOVER) && has_active));

  always_comb begin
    rtt_wr_en   = 1'b0;
    rtt_wr_addr = new_slot;
    rtt_wr_data = RTT_START;
    if (state == S_APPLY) begin
      if ((mode_q == MODE_ADD) && !full) begin
        rtt_wr_en = 1'b1;
      end else if ((mode_q == MODE_UPDATE) && idx_ok && up_q) begin
        rtt_wr_en   = 1'b1;
        rtt_wr_addr = idx_slot;
        rtt_wr_data = rtt_q;
      end
    end
  end

  mrps_rtt_scan #(.PATHS(PATHS)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rtt_wr_en),
    .wr_addr  (rtt_wr_addr),
    .wr_data  (rtt_wr_data),
    .start    (scan_start),
    .count    (paths_in_use),
    .up_flags (up_flags),
    .stat     (scan_stat),
    .best_idx (scan_best)
  );

  mrps_byte_bank #(.PATHS(PATHS)) u_bytes (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == S_BREAD),
    .rd_addr (target),
    .rd_data (byte_rd),
    .wr_en   ((state == S_BDATA) && (mode_q == MODE_ACCOUNT)),
    .wr_addr (target),
    .wr_data (byte_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      paths_in_use <= '0;
      has_active   <= 1'b0;
      active_slot  <= '0;
      up_flags     <= '0;
      up_total     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // In the finish state the response register decides for itself.
      if (out_valid && rsp.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q  <= req.mode;
            idx_q   <= req.path_index;
            up_q    <= req.link_up;
            rtt_q   <= req.rtt_value;
            bytes_q <= req.byte_count;
            state   <= S_APPLY;
          end
        end
        S_APPLY: begin
          status_q    <= ST_DONE;
          ret_valid_q <= 1'b0;
          ret_q       <= '0;
          pbytes_q    <= '0;
          state       <= S_FINISH;
          case (mode_q)
            MODE_ADD: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                up_flags[new_slot] <= 1'b1;
                up_total           <= up_total + CW'(1);
                if (!has_active) begin
                  has_active  <= 1'b1;
                  active_slot <= new_slot;
                end
                paths_in_use <= paths_in_use + CW'(1);
                ret_valid_q  <= 1'b1;
                ret_q        <= new_slot;
                target       <= new_slot;
                state        <= S_BREAD;
              end
            end
            MODE_UPDATE: begin
              if (!idx_ok) begin
                status_q <= ST_BAD_INDEX;
              end else begin
                up_flags[idx_slot] <= up_q;
                if (up_flags[idx_slot] != up_q) begin
                  up_total <= up_q ? (up_total + CW'(1)) : (up_total - CW'(1));
                end
                target <= idx_slot;
                state  <= S_BREAD;
              end
            end
            MODE_SELECT: begin
              state <= S_SCAN;
            end
            MODE_FAILOVER: begin
              if (!has_active) begin
                status_q <= ST_NO_ACTIVE;
              end else begin
                up_flags[active_slot] <= 1'b0;
                if (up_flags[active_slot]) begin
                  up_total <= up_total - CW'(1);
                end
                state <= S_SCAN;
              end
            end
            MODE_ACCOUNT: begin
              if (!idx_ok) begin
                status_q <= ST_BAD_INDEX;
              end else begin
                target <= idx_slot;
                state  <= S_BREAD;
              end
            end
            default: begin
              // Query, and the unused modes that behave as query.
              if (idx_ok) begin
                target <= idx_slot;
                state  <= S_BREAD;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (scan_stat.done) begin
            if (scan_stat.found) begin
              has_active  <= 1'b1;
              active_slot <= scan_best;
              ret_valid_q <= 1'b1;
              ret_q       <= scan_best;
              target      <= scan_best;
              state       <= S_BREAD;
            end else begin
              has_active  <= 1'b0;
              active_slot <= '0;
              status_q    <= ST_NO_ACTIVE;
              state       <= S_FINISH;
            end
          end
        end
        S_BREAD: begin
          state <= S_BDATA;
        end
        S_BDATA: begin
          pbytes_q <= (mode_q == MODE_ACCOUNT) ? byte_sum : byte_rd;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid          <= 1'b1;
            rsp.status         <= status_q;
            rsp.index_valid    <= ret_valid_q;
            rsp.returned_index <= ret_valid_q ? IDX_W'(ret_q) : '0;
            rsp.active_valid   <= has_active;
            rsp.active_path    <= has_active ? IDX_W'(active_slot) : '0;
            rsp.up_count       <= COUNT_W'(up_total);
            rsp.path_bytes     <= pbytes_q;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/mrps_byte_bank.sv */
// ----------------------------------------------------------------------------
// mrps_byte_bank
// Per-path byte counters: one write port, one registered read port.
// An entry that was never written reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrps_byte_bank import mrps_pkg::*; #(
  parameter int PATHS = PATHS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     rd_en,
  input  logic [((PATHS > 1) ? $clog2(PATHS) : 1)-1:0] rd_addr,
  output logic [BYTES_W-1:0]                       rd_data,
  input  logic                                     wr_en,
  input  logic [((PATHS > 1) ? $clog2(PATHS) : 1)-1:0] wr_addr,
  input  logic [BYTES_W-1:0]                       wr_data
);

  logic [BYTES_W-1:0] mem [PATHS];
  logic [PATHS-1:0]   written;
  logic [BYTES_W-1:0] mem_q;
  logic               hit_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      hit_q <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = hit_q ? mem_q : '0;

endmodule

/* rtl/core/mrps_rtt_scan.sv */
// ----------------------------------------------------------------------------
// mrps_rtt_scan
// RTT store and the shared compare unit that walks the paths in use, one per
// cycle, keeping the lowest-RTT up path. Ties keep the lower index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrps_rtt_scan import mrps_pkg::*; #(
  parameter int PATHS = PATHS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     wr_en,
  input  logic [((PATHS > 1) ? $clog2(PATHS) : 1)-1:0] wr_addr,
  input  logic [RTT_W-1:0]                         wr_data,
  input  logic                                     start,
  input  logic [$clog2(PATHS + 1)-1:0]             count,
  input  logic [PATHS-1:0]                         up_flags,
  output scan_stat_t                               stat,
  output logic [((PATHS > 1) ? $clog2(PATHS) : 1)-1:0] best_idx
);

  localparam int IW = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int CW = $clog2(PATHS + 1);

  logic [RTT_W-1:0] rtt_mem [PATHS];
  logic [RTT_W-1:0] rd_data;
  logic             run;
  logic [CW-1:0]    cnt;
  logic             rd_pend;
  logic [IW-1:0]    idx_d;
  logic [RTT_W-1:0] best_rtt;
  logic             found;
  logic             done;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rtt_mem[wr_addr] <= wr_data;
    end
    if (run) begin
      rd_data <= rtt_mem[IW'(cnt)];
    end
  end

  // Each entry is read into rd_data, then compared; done rises after the last compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      cnt     <= '0;
      rd_pend <= 1'b0;
      found   <= 1'b0;
      done    <= 1'b0;
    end else begin
      rd_pend <= run;
      done    <= 1'b0;
      if (start) begin
        run   <= (count != '0);
        cnt   <= '0;
        found <= 1'b0;
        done  <= (count == '0);
      end else begin
        if (run) begin
          idx_d <= IW'(cnt);
          cnt   <= cnt + CW'(1);
          if (cnt + CW'(1) == count) begin
            run <= 1'b0;
          end
        end
        if (rd_pend) begin
          if (up_flags[idx_d] && (!found || rd_data < best_rtt)) begin
            found    <= 1'b1;
            best_rtt <= rd_data;
            best_idx <= idx_d;
          end
          if (!run) begin
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign stat.done  = done;
  assign stat.found = found;

endmodule

/* rtl/core/mrps_checker.sv */
// ----------------------------------------------------------------------------
// mrps_checker
// Port-level checks on the path selector, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_rtt_path_failover_selector_defines.svh"

module mrps_checker import mrps_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic                rsp_index_valid,
  input logic [IDX_W-1:0]    rsp_returned_index,
  input logic                rsp_active_valid,
  input logic [IDX_W-1:0]    rsp_active_path
);

  // The block works on one request at a time.
  `MRPS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

  // A returned index only comes with a successful request.
  `MRPS_ASSERT_NOW(a_index_needs_done, rsp_valid && rsp_index_valid, rsp_status == ST_DONE, "index with error status")

  `MRPS_ASSERT_NOW(a_index_zero, rsp_valid && !rsp_index_valid, rsp_returned_index == '0, "stale returned index")

  `MRPS_ASSERT_NOW(a_active_zero, rsp_valid && !rsp_active_valid, rsp_active_path == '0, "stale active path")

  `MRPS_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

endmodule

bind min_rtt_path_failover_selector mrps_checker u_mrps_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_index_valid    (rsp.index_valid),
  .rsp_returned_index (rsp.returned_index),
  .rsp_active_valid   (rsp.active_valid),
  .rsp_active_path    (rsp.active_path)
);
